FILE: design/smt_pkg.sv
package smt_pkg;

    // Field widths of the item and result ports
    localparam int CMD_W      = 2;
    localparam int ROW_W      = 6;
    localparam int COL_W      = 11;
    localparam int VAL_W      = 32;
    localparam int OROW_W     = 11;
    localparam int OCOL_W     = 7;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;
    localparam int NUM_ROWS_W = 7;
    localparam int NUM_COLS_W = 11;

    localparam logic [NUM_ROWS_W-1:0] NUM_ROWS_RST = 7'd64;
    localparam logic [NUM_COLS_W-1:0] NUM_COLS_RST = 11'd1024;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'd1;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EMIT  = 2'd2;

    // Most results one emit may give
    localparam int RESULT_LIMIT = 64;
    localparam int RES_CNT_W    = 7;

    // Control sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_FLUSH
    } t_state;

endpackage

FILE: design/sparse_matrix_transpose_unit.sv
// Channel   | Direction | Handshake               | Payload
// ----------+-----------+-------------------------+------------------------------------------
// in        | slave     | i_in_valid / o_in_stall | i_cmd, i_entry_row/col/value
// out       | master    | o_out_valid/i_out_stall | o_out_row/col/value, o_row_empty, o_last,
//           |           |                         | o_overflow
// cfg       | slave     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// Clear and unused commands finish on acceptance; a load reads the row table, then writes it.
// In an emit, the scan reads one row descriptor from the row table memory per cycle while not
// held, then the entry memories, then writes the cursor back. The scan is held only when a new
// hit finds a pending result still unsent while the output register is stalled.
// Reset (synchronous, active low) clears the row valid flags at once; no clearing pass.
// One item is worked on at a time; o_in_stall is high while a load or emit is running.
module sparse_matrix_transpose_unit #(
    parameter int MAX_ROWS    = 64,
    parameter int MAX_COLS    = 1024,
    parameter int MAX_ENTRIES = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // item channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [smt_pkg::CMD_W-1:0]           i_cmd,
    input  logic [smt_pkg::ROW_W-1:0]           i_entry_row,
    input  logic [smt_pkg::COL_W-1:0]           i_entry_col,
    input  logic signed [smt_pkg::VAL_W-1:0]    i_entry_value,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [smt_pkg::OROW_W-1:0]          o_out_row,
    output logic [smt_pkg::OCOL_W-1:0]          o_out_col,
    output logic signed [smt_pkg::VAL_W-1:0]    o_out_value,
    output logic                                o_row_empty,
    output logic                                o_last,
    output logic                                o_overflow,
    // configuration channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [smt_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [smt_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import smt_pkg::*;

    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RCW = ($clog2(MAX_ROWS + 1) > NUM_ROWS_W) ? $clog2(MAX_ROWS + 1) : NUM_ROWS_W;
    localparam int CW  = ($clog2(MAX_COLS + 2) > COL_W) ? $clog2(MAX_COLS + 2) : COL_W;
    localparam int EAW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNW = $clog2(MAX_ENTRIES + 1);

    typedef struct packed {
        logic [EAW-1:0] start;
        logic [CNW-1:0] count;
        logic [CNW-1:0] cursor;
    } t_row_ent;

    // Memories: row descriptors and the entry store
    t_row_ent                r_rt_mem [MAX_ROWS];
    logic [COL_W-1:0]        r_ec_mem [MAX_ENTRIES];
    logic signed [VAL_W-1:0] r_ev_mem [MAX_ENTRIES];
    t_row_ent                r_rt_q;
    logic [COL_W-1:0]        r_ec_q;
    logic signed [VAL_W-1:0] r_ev_q;

    // Control state
    t_state                  r_state, n_state;
    logic [NUM_ROWS_W-1:0]   r_num_rows;
    logic [NUM_COLS_W-1:0]   r_num_cols;
    logic [MAX_ROWS-1:0]     r_row_vld;
    logic [CNW-1:0]          r_fill;
    logic [CW-1:0]           r_nor;
    logic [ROW_W-1:0]        r_last_row;
    logic [COL_W-1:0]        r_last_col;
    logic                    r_ovf;
    logic [RCW-1:0]          r_j;
    logic [RES_CNT_W-1:0]    r_n;
    logic                    r_past;
    logic                    r_s1_vld, r_s1_rv, r_s2_vld;
    logic                    r_pd_vld, r_out_vld;

    // Payload state
    logic [ROW_W-1:0]        r_ld_row;
    logic [COL_W-1:0]        r_ld_col;
    logic signed [VAL_W-1:0] r_ld_val;
    logic [RW-1:0]           r_s1_j, r_s2_j;
    t_row_ent                r_s2_rt;
    logic [OCOL_W-1:0]       r_pd_col;
    logic signed [VAL_W-1:0] r_pd_val;
    logic [OROW_W-1:0]       r_out_row;
    logic [OCOL_W-1:0]       r_out_col;
    logic signed [VAL_W-1:0] r_out_value;
    logic                    r_out_empty, r_out_last, r_out_ovf;

    // Combinational control
    logic                    in_acc, cfg_acc, out_free, past_end, ld_ok, pos_gt;
    logic [RCW-1:0]          eff_rows;
    logic [CW-1:0]           eff_cols;
    logic [RW-1:0]           ld_idx;
    logic                    s2_hit, s1_go, hold, adv, issue, scan_done;
    logic                    rt_re, rt_we, ent_re, ent_we;
    logic [RW-1:0]           rt_ra, rt_wa;
    t_row_ent                rt_wd;
    logic [EAW-1:0]          ent_ra;
    logic                    push, push_last, push_empty;
    logic [OROW_W-1:0]       push_row;
    logic [OCOL_W-1:0]       push_col;
    logic signed [VAL_W-1:0] push_val;

    // Handshakes and effective sizes
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign out_free    = !r_out_vld || !i_out_stall;

    assign eff_rows = (RCW'(r_num_rows) < RCW'(MAX_ROWS)) ? RCW'(r_num_rows) : RCW'(MAX_ROWS);
    assign eff_cols = (CW'(r_num_cols) < CW'(MAX_COLS)) ? CW'(r_num_cols) : CW'(MAX_COLS);
    assign past_end = (r_nor == '0) || (r_nor > eff_cols);

    // Load checks; columns never reach MAX_COLS + 1, so order is (row, col) order
    assign ld_idx = RW'(r_ld_row);
    assign pos_gt = (r_ld_row > r_last_row) ||
                    ((r_ld_row == r_last_row) && (r_ld_col > r_last_col));
    assign ld_ok  = (RCW'(r_ld_row) < eff_rows) && (r_ld_col != '0) &&
                    (CW'(r_ld_col) <= eff_cols) && pos_gt &&
                    (r_fill < CNW'(MAX_ENTRIES));

    // Scan pipeline: stage 1 has the row descriptor, stage 2 the entry
    assign s1_go     = r_s1_vld && r_s1_rv && (r_rt_q.cursor < r_rt_q.count);
    assign s2_hit    = r_s2_vld && (CW'(r_ec_q) == r_nor) &&
                       (r_n < RES_CNT_W'(RESULT_LIMIT));
    assign hold      = s2_hit && r_pd_vld && !out_free;
    assign adv       = (r_state == ST_SCAN) && !hold;
    assign issue     = adv && (r_j < eff_rows);
    assign scan_done = (r_j >= eff_rows) && !r_s1_vld && !r_s2_vld;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_cmd == CMD_LOAD) begin
                        n_state = ST_LOAD;
                    end else if (i_cmd == CMD_EMIT) begin
                        n_state = past_end ? ST_FLUSH : ST_SCAN;
                    end
                end
            end
            ST_LOAD:  n_state = ST_IDLE;
            ST_SCAN: begin
                if (scan_done) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // Memory controls and result push
    always_comb begin
        rt_re      = 1'b0;
        rt_ra      = r_j[RW-1:0];
        rt_we      = 1'b0;
        rt_wa      = r_s2_j;
        rt_wd      = '{start: r_s2_rt.start, count: r_s2_rt.count,
                       cursor: CNW'(r_s2_rt.cursor + 1'b1)};
        ent_re     = 1'b0;
        ent_ra     = EAW'(r_rt_q.start + r_rt_q.cursor);
        ent_we     = 1'b0;
        push       = 1'b0;
        push_last  = 1'b0;
        push_empty = 1'b0;
        push_row   = OROW_W'(r_nor);
        push_col   = r_pd_col;
        push_val   = r_pd_val;
        case (r_state)
            ST_IDLE: begin
                rt_re = 1'b1;
                rt_ra = RW'(i_entry_row);
            end
            ST_LOAD: begin
                rt_we  = ld_ok;
                ent_we = ld_ok;
                rt_wa  = ld_idx;
                if (r_row_vld[ld_idx]) begin
                    rt_wd = '{start: r_rt_q.start, count: CNW'(r_rt_q.count + 1'b1),
                              cursor: r_rt_q.cursor};
                end else begin
                    rt_wd = '{start: EAW'(r_fill), count: CNW'(1), cursor: '0};
                end
            end
            ST_SCAN: begin
                rt_re  = issue;
                ent_re = adv;
                rt_we  = adv && s2_hit;
                // a new hit sends the held one on as a non-final result
                push   = adv && s2_hit && r_pd_vld;
            end
            ST_FLUSH: begin
                push      = out_free;
                push_last = 1'b1;
                if (r_past) begin
                    push_empty = 1'b1;
                    push_row   = '0;
                    push_col   = '0;
                    push_val   = '0;
                end else if (!r_pd_vld) begin
                    push_empty = 1'b1;
                    push_col   = '0;
                    push_val   = '0;
                end
            end
            default: begin
                rt_re = 1'b0;
            end
        endcase
    end

    // Row descriptor memory
    always_ff @(posedge i_clk) begin
        if (rt_we) begin
            r_rt_mem[rt_wa] <= rt_wd;
        end
        if (rt_re) begin
            r_rt_q <= r_rt_mem[rt_ra];
        end
    end

    // Entry memories
    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            r_ec_mem[r_fill[EAW-1:0]] <= r_ld_col;
            r_ev_mem[r_fill[EAW-1:0]] <= r_ld_val;
        end
        if (ent_re) begin
            r_ec_q <= r_ec_mem[ent_ra];
            r_ev_q <= r_ev_mem[ent_ra];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_num_rows <= NUM_ROWS_RST;
            r_num_cols <= NUM_COLS_RST;
            r_row_vld  <= '0;
            r_fill     <= '0;
            r_nor      <= CW'(1);
            r_last_row <= '0;
            r_last_col <= '0;
            r_ovf      <= 1'b0;
            r_j        <= '0;
            r_n        <= '0;
            r_past     <= 1'b0;
            r_s1_vld   <= 1'b0;
            r_s1_rv    <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_pd_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;

            // configuration writes
            if (cfg_acc) begin
                if (i_cfg_index == REG_NUM_ROWS) begin
                    r_num_rows <= i_cfg_data[NUM_ROWS_W-1:0];
                end else begin
                    r_num_cols <= i_cfg_data[NUM_COLS_W-1:0];
                end
            end

            // output register
            if (push) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        case (i_cmd)
                            CMD_CLEAR: begin
                                r_row_vld  <= '0;
                                r_fill     <= '0;
                                r_nor      <= CW'(1);
                                r_last_row <= '0;
                                r_last_col <= '0;
                                r_ovf      <= 1'b0;
                            end
                            CMD_EMIT: begin
                                r_j      <= '0;
                                r_n      <= '0;
                                r_past   <= past_end;
                                r_s1_vld <= 1'b0;
                                r_s2_vld <= 1'b0;
                                r_pd_vld <= 1'b0;
                            end
                            default: begin
                                r_past <= r_past;
                            end
                        endcase
                    end
                end
                ST_LOAD: begin
                    if (ld_ok) begin
                        r_row_vld[ld_idx] <= 1'b1;
                        r_fill            <= CNW'(r_fill + 1'b1);
                        r_last_row        <= r_ld_row;
                        r_last_col        <= r_ld_col;
                    end else begin
                        r_ovf <= 1'b1;
                    end
                end
                ST_SCAN: begin
                    if (adv) begin
                        r_s1_vld <= issue;
                        r_s1_rv  <= r_row_vld[r_j[RW-1:0]];
                        r_s2_vld <= s1_go;
                        if (issue) begin
                            r_j <= RCW'(r_j + 1'b1);
                        end
                        if (s2_hit) begin
                            r_n      <= RES_CNT_W'(r_n + 1'b1);
                            r_pd_vld <= 1'b1;
                        end
                    end
                end
                ST_FLUSH: begin
                    if (out_free) begin
                        r_pd_vld <= 1'b0;
                        if (!r_past) begin
                            r_nor <= CW'(r_nor + 1'b1);
                        end
                    end
                end
                default: begin
                    r_past <= r_past;
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ld_row <= i_entry_row;
            r_ld_col <= i_entry_col;
            r_ld_val <= i_entry_value;
        end
        if (adv) begin
            r_s1_j  <= r_j[RW-1:0];
            r_s2_j  <= r_s1_j;
            r_s2_rt <= r_rt_q;
            if (s2_hit) begin
                r_pd_col <= OCOL_W'(RCW'(r_s2_j) + RCW'(1));
                r_pd_val <= r_ev_q;
            end
        end
        if (push) begin
            r_out_row   <= push_row;
            r_out_col   <= push_col;
            r_out_value <= push_val;
            r_out_empty <= push_empty;
            r_out_last  <= push_last;
            r_out_ovf   <= r_ovf;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_out_value = r_out_value;
    assign o_row_empty = r_out_empty;
    assign o_last      = r_out_last;
    assign o_overflow  = r_out_ovf;

endmodule

FILE: design/smt_checker.sv
module smt_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_stall,
    input logic [smt_pkg::CMD_W-1:0]        i_cmd,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input logic [smt_pkg::OROW_W-1:0]       o_out_row,
    input logic [smt_pkg::OCOL_W-1:0]       o_out_col,
    input logic signed [smt_pkg::VAL_W-1:0] o_out_value,
    input logic                             o_row_empty,
    input logic                             o_last,
    input logic                             o_cfg_ready
);
    import smt_pkg::*;

    // A stalled result stays, with its row, column, value and last flag unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_row) &&
            $stable(o_out_col) && $stable(o_out_value) && $stable(o_last))
        else $error("result changed while stalled");

    // An empty-row item is always the final one of its emit and carries no entry
    a_empty_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_row_empty |-> o_last && (o_out_col == '0) && (o_out_value == '0))
        else $error("empty result malformed");

    // Loads and emits occupy the block for at least the following cycle
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && ((i_cmd == CMD_LOAD) || (i_cmd == CMD_EMIT))
            |=> o_in_stall)
        else $error("block not busy after load or emit");

    // Configuration is only taken while no item is in work
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> !o_cfg_ready)
        else $error("configuration open while busy");

endmodule

bind sparse_matrix_transpose_unit smt_checker u_smt_checker (.*);
